// ===== rtl/modexp_pkg.sv =====
// Shared types for the modular exponentiation block: request and result words,
// sequencer states and the status word of the shared modular multiplier.
// No dependencies.
`timescale 1ns / 1ps

package modexp_pkg;

  // Request word: operands of one exponentiation
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] exponent;
    logic [31:0] modulus;
  } modexp_req_t;

  // Result word
  typedef struct packed {
    logic [31:0] power_result;
    logic        bad_modulus;
  } modexp_res_t;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT
  } modexp_state_t;

  // Status of the shared multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } modexp_mul_stat_t;

endpackage

// ===== rtl/modexp_mulmod.sv =====
// Bit-serial modular multiplier: x * y mod m by double-and-add, one bit of y per cycle.
// Depends on modexp_pkg for the status word.
`timescale 1ns / 1ps

module modexp_mulmod
  import modexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [OPERAND_WIDTH-1:0] x,
  input  logic [OPERAND_WIDTH-1:0] y,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic [OPERAND_WIDTH-1:0] product,
  output modexp_mul_stat_t         stat
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic             running;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     acc;
  logic [W-1:0]     x_r;
  logic [W-1:0]     y_r;
  logic [W-1:0]     m_r;
  logic [W-1:0]     acc_next;

  // One step: t = 2*acc + bit*x stays below 3m, so subtract m or 2m at most
  logic [W+2:0] t;
  logic [W+2:0] sub1;
  logic [W+2:0] sub2;

  always_comb begin
    t    = {2'b00, acc, 1'b0} + (y_r[W-1] ? {3'b000, x_r} : '0);
    sub1 = t - {3'b000, m_r};
    sub2 = t - {2'b00, m_r, 1'b0};
    if (!sub2[W+2]) begin
      acc_next = sub2[W-1:0];
    end else if (!sub1[W+2]) begin
      acc_next = sub1[W-1:0];
    end else begin
      acc_next = t[W-1:0];
    end
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: operands latched at go, y shifted out MSB first
  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= x;
      y_r <= y;
      m_r <= m;
      acc <= '0;
    end else if (running) begin
      acc <= acc_next;
      y_r <= {y_r[W-2:0], 1'b0};
    end
  end

  assign product   = acc;
  assign stat.busy = running;
  assign stat.done = done;

  // Running remainder never reaches the modulus
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    running |-> (acc < m_r))
    else $error("mulmod accumulator not reduced");

  // Completion pulse follows the last step
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(running) && !running)
    else $error("mulmod done without a finished run");

  // A new operation never starts over a running one
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> !running)
    else $error("mulmod restarted while running");

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation top level: square-and-multiply sequencer around one shared
// bit-serial modular multiplier (modexp_mulmod). Depends on modexp_pkg.
//
//  channel   ports                   handshake
//  --------  ----------------------  -----------------------------------------
//  request   request (modexp_req_t)  word taken when start is high, busy low
//  result    result (modexp_res_t)   word valid for the one cycle done is high
//
// Every modular multiplication runs in the shared multiplier. With W = OPERAND_WIDTH,
// an item runs one base reduction, W squarings and one multiply per set exponent
// bit. A zero modulus is answered in the cycle after accept.
// Reset clears the sequencer and the strobe. The receiver cannot stall: done is a
// one-cycle pulse, and a new start may be taken in that same cycle.
`timescale 1ns / 1ps

module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  modexp_req_t request,
  output logic        busy,
  output logic        done,
  output modexp_res_t result
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  modexp_state_t    st, st_next;
  logic             launch, launch_next;
  logic             done_next;
  modexp_res_t      result_next;
  logic [W-1:0]     base_r, base_next;
  logic [W-1:0]     exp_r, exp_next;
  logic [W-1:0]     mod_r, mod_next;
  logic [W-1:0]     acc_r, acc_next;
  logic [CNT_W-1:0] bit_cnt, bit_cnt_next;

  logic [W-1:0]     mul_x;
  logic [W-1:0]     mul_y;
  logic [W-1:0]     mul_p;
  modexp_mul_stat_t mul_stat;

  // Operand fields cut or zero-extended to the datapath width
  logic [W+31:0] base_ext;
  logic [W+31:0] exp_ext;
  logic [W+31:0] mod_ext;
  logic [W+31:0] acc_ext;

  assign base_ext = {{W{1'b0}}, request.base};
  assign exp_ext  = {{W{1'b0}}, request.exponent};
  assign mod_ext  = {{W{1'b0}}, request.modulus};
  // final product of the last multiplication, sized to the result field
  assign acc_ext  = {32'd0, mul_p};

  // Multiplier operands by phase
  always_comb begin
    unique case (st)
      ST_REDUCE: begin
        mul_x = W'(1);
        mul_y = base_r;
      end
      ST_SQUARE: begin
        mul_x = acc_r;
        mul_y = acc_r;
      end
      default: begin
        mul_x = acc_r;
        mul_y = base_r;
      end
    endcase
  end

  modexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .go      (launch),
    .x       (mul_x),
    .y       (mul_y),
    .m       (mod_r),
    .product (mul_p),
    .stat    (mul_stat)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    logic next_bit;
    next_bit     = 1'b0;
    st_next      = st;
    launch_next  = 1'b0;
    done_next    = 1'b0;
    result_next  = result;
    base_next    = base_r;
    exp_next     = exp_r;
    mod_next     = mod_r;
    acc_next     = acc_r;
    bit_cnt_next = bit_cnt;

    unique case (st)
      ST_IDLE: begin
        if (start) begin
          base_next = base_ext[W-1:0];
          exp_next  = exp_ext[W-1:0];
          mod_next  = mod_ext[W-1:0];
          if (mod_ext[W-1:0] == '0) begin
            result_next.power_result = '0;
            result_next.bad_modulus  = 1'b1;
            done_next                = 1'b1;
          end else begin
            st_next     = ST_REDUCE;
            launch_next = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_stat.done) begin
          base_next    = mul_p;
          acc_next     = (mod_r == W'(1)) ? '0 : W'(1);
          bit_cnt_next = CNT_W'(W - 1);
          st_next      = ST_SQUARE;
          launch_next  = 1'b1;
        end
      end
      ST_SQUARE: begin
        if (mul_stat.done) begin
          acc_next = mul_p;
          if (exp_r[W-1]) begin
            st_next     = ST_MULT;
            launch_next = 1'b1;
          end else begin
            next_bit = 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mul_stat.done) begin
          acc_next = mul_p;
          next_bit = 1'b1;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase

    // Advance to the next exponent bit or finish
    if (next_bit) begin
      exp_next = {exp_r[W-2:0], 1'b0};
      if (bit_cnt == '0) begin
        st_next                  = ST_IDLE;
        result_next.power_result = acc_ext[31:0];
        result_next.bad_modulus  = 1'b0;
        done_next                = 1'b1;
      end else begin
        bit_cnt_next = bit_cnt - 1'b1;
        st_next      = ST_SQUARE;
        launch_next  = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      st     <= st_next;
      launch <= launch_next;
      done   <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    result  <= result_next;
    base_r  <= base_next;
    exp_r   <= exp_next;
    mod_r   <= mod_next;
    acc_r   <= acc_next;
    bit_cnt <= bit_cnt_next;
  end

  assign busy = (st != ST_IDLE);

  // An error word carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bad_modulus) |-> (result.power_result == '0))
    else $error("bad modulus word with nonzero result");

  // A good result is reduced by its modulus
  a_res_reduced: assert property (@(posedge clk) disable iff (rst)
    (done && !result.bad_modulus) |-> (acc_r < mod_r))
    else $error("result not reduced");

  // The multiplier is only launched while it is idle and the sequencer is busy
  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    launch |-> (!mul_stat.busy && busy))
    else $error("multiplier launched while running");

endmodule
